// File: rtl/fgos_pkg.sv
// fgos_pkg: types and constants for the face gaze offset smoother.
// Used by face_gaze_offset_smoother_top; no dependencies.
package fgos_pkg;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_SLOAD,
        ST_SMUL,
        ST_SADD,
        ST_CLOAD,
        ST_SCALE,
        ST_FIN
    } state_t;

    typedef enum logic [2:0]
    {
        CFG_SMOOTH = 3'd0,
        CFG_MAX_OFS = 3'd1,
        CFG_STABLE = 3'd2,
        CFG_JITTER = 3'd3,
        CFG_TRACK = 3'd4,
        CFG_INVERT = 3'd5
    } cfg_idx_t;

    localparam int PIX_W = 8;
    localparam int FRAC_W = 14;
    localparam int DIV_W = PIX_W + FRAC_W;
    localparam int REM_W = 7;
    localparam int POS_W = 16;
    localparam int MAG_W = 16;
    localparam int FACT_W = 17;
    localparam int ACC_W = MAG_W + FACT_W;
    localparam int MPO_W = 8;
    localparam int OFS_W = 13;
    localparam int THR_W = 15;
    localparam int CFG_W = 17;
    localparam int CNT_W = 5;

    localparam logic [DIV_W-1:0] ONE_Q14 = DIV_W'(16384);
    localparam logic [FACT_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    localparam logic [FACT_W-1:0] RST_SMOOTH = 17'd32768;
    localparam logic [MPO_W-1:0] RST_MAX_OFS = 8'd60;
    localparam logic [7:0] RST_STABLE = 8'd1;
    localparam logic [THR_W-1:0] RST_JITTER = 15'd3277;

endpackage

// File: rtl/face_gaze_offset_smoother_top.sv
// face_gaze_offset_smoother_top: face centre to smoothed eye offset, bit-serial datapath.
// Depends on fgos_pkg.
//
//  channel  | dir | payload (lsb first)
//  s_*      | in  | tdata: face_x[7:0], face_y[15:8]; tuser: kind
//  m_*      | out | tdata: eye_x[12:0], eye_y[25:13], face_present, target_valid
//  cfg_*    | in  | cfg_index selects register, cfg_wdata value, cfg_we strobe
//
// A face item passes from acceptance to result through restoring division by
// SCREEN_HALF, a shift-add smoothing multiply and a shift-add scaling, plus
// sequencing. Reset and ignored items go through the scaling only.
// One item is in work at a time; s_tready is high only in the idle state.
// The result register holds a pending transaction while the next item is accepted;
// the sequencer waits at the end of an item only while that register is full and m_tready is low.
// rst_n clears all tracking state and returns the registers to their defaults.
module face_gaze_offset_smoother_top
    import fgos_pkg::*;
#(
    parameter int SCREEN_HALF = 120
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // face_x[7:0], face_y[15:8]
    input  logic                s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // eye_x, eye_y, face_present, target_valid
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    localparam logic [PIX_W-1:0] HALF_PIX = PIX_W'(SCREEN_HALF);
    localparam logic [DIV_W-1:0] HALF_RND = DIV_W'(SCREEN_HALF / 2);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;

    logic [FACT_W-1:0] smooth_reg;
    logic [MPO_W-1:0] max_ofs_reg;
    logic [7:0] stable_need_reg;
    logic [THR_W-1:0] jitter_reg;
    logic track_reg;
    logic invert_reg;

    logic signed [POS_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [POS_W-1:0] tgt_x_reg, tgt_y_reg;
    logic signed [POS_W-1:0] sm_x_reg, sm_y_reg;
    logic [7:0] stable_cnt_reg;
    logic init_reg, seen_reg, tvalid_reg;

    logic [DIV_W-1:0] qx_reg, qy_reg;
    logic [REM_W-1:0] rx_reg, ry_reg;
    logic negx_reg, negy_reg;
    logic [MAG_W-1:0] mcx_reg, mcy_reg;
    logic [ACC_W-1:0] accx_reg, accy_reg;
    logic [FACT_W-1:0] mplr_reg;
    logic sgnx_reg, sgny_reg;

    logic m_valid_reg;
    logic [31:0] m_data_reg;

    logic accept;
    logic out_free;
    logic [PIX_W-1:0] pix_x, pix_y, magx, magy;
    logic [PIX_W:0] rshx, rshy;
    logic bitx, bity;
    logic [DIV_W-1:0] qcx, qcy;
    logic signed [POS_W-1:0] nx, ny;
    logic [POS_W:0] dfx, dfy, adx, ady;
    logic [POS_W:0] thr1, thr2;
    logic big_move, small_move;
    logic [7:0] cnt_clr, cnt_new;
    logic latch;
    logic [FACT_W-1:0] f_eff;
    logic [POS_W:0] sdx, sdy;
    logic [ACC_W-1:0] rndx, rndy;
    logic [POS_W:0] stx, sty;
    logic [22:0] osx, osy;
    logic [OFS_W-1:0] omx, omy, ofx, ofy;

    // handshake outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = m_valid_reg;
        m_tdata = m_data_reg;
    end

    assign accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!s_tuser && track_reg)
                        state_next = ST_DIV;
                    else
                        state_next = ST_CLOAD;
                end
            end
            ST_DIV:   if (cnt_reg == '0) state_next = ST_UPD;
            ST_UPD:   state_next = ST_SLOAD;
            ST_SLOAD: state_next = ST_SMUL;
            ST_SMUL:  if (cnt_reg == '0) state_next = ST_SADD;
            ST_SADD:  state_next = ST_CLOAD;
            ST_CLOAD: state_next = ST_SCALE;
            ST_SCALE: if (cnt_reg == '0) state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // input pixel to magnitude of (p - SCREEN_HALF)
    assign pix_x = s_tdata[7:0];
    assign pix_y = s_tdata[15:8];
    assign magx = (pix_x >= HALF_PIX) ? pix_x - HALF_PIX : HALF_PIX - pix_x;
    assign magy = (pix_y >= HALF_PIX) ? pix_y - HALF_PIX : HALF_PIX - pix_y;

    // restoring division step
    assign rshx = {rx_reg, qx_reg[DIV_W-1]};
    assign rshy = {ry_reg, qy_reg[DIV_W-1]};
    assign bitx = (rshx >= {1'b0, HALF_PIX});
    assign bity = (rshy >= {1'b0, HALF_PIX});

    // clamp, sign, jitter test
    assign qcx = (qx_reg > ONE_Q14) ? ONE_Q14 : qx_reg;
    assign qcy = (qy_reg > ONE_Q14) ? ONE_Q14 : qy_reg;
    assign nx = negx_reg ? -$signed(qcx[POS_W-1:0]) : $signed(qcx[POS_W-1:0]);
    assign ny = negy_reg ? -$signed(qcy[POS_W-1:0]) : $signed(qcy[POS_W-1:0]);
    assign dfx = {nx[POS_W-1], nx} - {prev_x_reg[POS_W-1], prev_x_reg};
    assign dfy = {ny[POS_W-1], ny} - {prev_y_reg[POS_W-1], prev_y_reg};
    assign adx = dfx[POS_W] ? -dfx : dfx;
    assign ady = dfy[POS_W] ? -dfy : dfy;
    assign thr1 = {2'b00, jitter_reg};
    assign thr2 = {1'b0, jitter_reg, 1'b0};
    assign big_move = (adx > thr2) || (ady > thr2);
    assign small_move = (adx < thr1) && (ady < thr1);

    always_comb
    begin
        cnt_clr = big_move ? 8'd0 : stable_cnt_reg;
        if (!init_reg)
            cnt_new = stable_cnt_reg;
        else if (small_move)
            cnt_new = (cnt_clr < COUNT_MAX) ? cnt_clr + 8'd1 : cnt_clr;
        else
            cnt_new = (cnt_clr != 8'd0) ? cnt_clr - 8'd1 : cnt_clr;
    end

    assign latch = (cnt_new >= stable_need_reg);

    // smoothing
    assign f_eff = (smooth_reg > ONE_Q16) ? ONE_Q16 : smooth_reg;
    assign sdx = {tgt_x_reg[POS_W-1], tgt_x_reg} - {sm_x_reg[POS_W-1], sm_x_reg};
    assign sdy = {tgt_y_reg[POS_W-1], tgt_y_reg} - {sm_y_reg[POS_W-1], sm_y_reg};
    assign rndx = accx_reg + ACC_W'(32768);
    assign rndy = accy_reg + ACC_W'(32768);
    assign stx = sgnx_reg ? -rndx[ACC_W-1:16] : rndx[ACC_W-1:16];
    assign sty = sgny_reg ? -rndy[ACC_W-1:16] : rndy[ACC_W-1:16];

    // output scaling
    assign osx = accx_reg[22:0] + 23'd512;
    assign osy = accy_reg[22:0] + 23'd512;
    assign omx = osx[22:10];
    assign omy = osy[22:10];
    assign ofx = sgnx_reg ? -omx : omx;
    assign ofy = sgny_reg ? -omy : omy;

    // control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
            smooth_reg <= RST_SMOOTH;
            max_ofs_reg <= RST_MAX_OFS;
            stable_need_reg <= RST_STABLE;
            jitter_reg <= RST_JITTER;
            track_reg <= 1'b1;
            invert_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SMOOTH:  smooth_reg <= cfg_wdata;
                    CFG_MAX_OFS: max_ofs_reg <= cfg_wdata[MPO_W-1:0];
                    CFG_STABLE:  stable_need_reg <= cfg_wdata[7:0];
                    CFG_JITTER:  jitter_reg <= cfg_wdata[THR_W-1:0];
                    CFG_TRACK:   track_reg <= cfg_wdata[0];
                    CFG_INVERT:  invert_reg <= cfg_wdata[0];
                    default:     ;
                endcase
            end
        end
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            tgt_x_reg <= '0;
            tgt_y_reg <= '0;
            sm_x_reg <= '0;
            sm_y_reg <= '0;
            stable_cnt_reg <= '0;
            init_reg <= 1'b0;
            seen_reg <= 1'b0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && s_tuser)
                    begin
                        prev_x_reg <= '0;
                        prev_y_reg <= '0;
                        tgt_x_reg <= '0;
                        tgt_y_reg <= '0;
                        sm_x_reg <= '0;
                        sm_y_reg <= '0;
                        stable_cnt_reg <= '0;
                        init_reg <= 1'b0;
                        seen_reg <= 1'b0;
                        tvalid_reg <= 1'b0;
                    end
                end
                ST_UPD:
                begin
                    stable_cnt_reg <= cnt_new;
                    prev_x_reg <= nx;
                    prev_y_reg <= ny;
                    if (latch)
                    begin
                        tgt_x_reg <= nx;
                        tgt_y_reg <= ny;
                        tvalid_reg <= 1'b1;
                    end
                    seen_reg <= 1'b1;
                    init_reg <= 1'b1;
                end
                ST_SADD:
                begin
                    sm_x_reg <= sm_x_reg + $signed(stx[POS_W-1:0]);
                    sm_y_reg <= sm_y_reg + $signed(sty[POS_W-1:0]);
                end
                default: ;
            endcase
        end
    end

    // serial datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                qx_reg <= {magx, FRAC_W'(0)} + HALF_RND;
                qy_reg <= {magy, FRAC_W'(0)} + HALF_RND;
                rx_reg <= '0;
                ry_reg <= '0;
                negx_reg <= (pix_x < HALF_PIX) ^ invert_reg;
                negy_reg <= (pix_y < HALF_PIX);
                cnt_reg <= CNT_W'(DIV_W - 1);
            end
            ST_DIV:
            begin
                rx_reg <= bitx ? REM_W'(rshx - {1'b0, HALF_PIX}) : rshx[REM_W-1:0];
                ry_reg <= bity ? REM_W'(rshy - {1'b0, HALF_PIX}) : rshy[REM_W-1:0];
                qx_reg <= {qx_reg[DIV_W-2:0], bitx};
                qy_reg <= {qy_reg[DIV_W-2:0], bity};
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_SLOAD:
            begin
                mcx_reg <= sdx[POS_W] ? MAG_W'(-sdx) : sdx[MAG_W-1:0];
                mcy_reg <= sdy[POS_W] ? MAG_W'(-sdy) : sdy[MAG_W-1:0];
                sgnx_reg <= sdx[POS_W];
                sgny_reg <= sdy[POS_W];
                mplr_reg <= f_eff;
                accx_reg <= '0;
                accy_reg <= '0;
                cnt_reg <= CNT_W'(FACT_W - 1);
            end
            ST_CLOAD:
            begin
                mcx_reg <= sm_x_reg[POS_W-1] ? MAG_W'(-sm_x_reg) : MAG_W'(sm_x_reg);
                mcy_reg <= sm_y_reg[POS_W-1] ? MAG_W'(-sm_y_reg) : MAG_W'(sm_y_reg);
                sgnx_reg <= sm_x_reg[POS_W-1];
                sgny_reg <= sm_y_reg[POS_W-1];
                mplr_reg <= {max_ofs_reg, (FACT_W - MPO_W)'(0)};
                accx_reg <= '0;
                accy_reg <= '0;
                cnt_reg <= CNT_W'(MPO_W - 1);
            end
            ST_SMUL, ST_SCALE:
            begin
                accx_reg <= {accx_reg[ACC_W-2:0], 1'b0}
                    + (mplr_reg[FACT_W-1] ? {FACT_W'(0), mcx_reg} : ACC_W'(0));
                accy_reg <= {accy_reg[ACC_W-2:0], 1'b0}
                    + (mplr_reg[FACT_W-1] ? {FACT_W'(0), mcy_reg} : ACC_W'(0));
                mplr_reg <= {mplr_reg[FACT_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_FIN:
            begin
                if (out_free)
                    m_data_reg <= {4'b0000, tvalid_reg, seen_reg, ofy, ofx};
            end
            default: ;
        endcase
    end

endmodule
